### hdl/epsf_pkg.sv
package epsf_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned EnergyW = 24;
  localparam int unsigned MarginW = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned BoxW    = 18;

  localparam logic signed [BoxW-1:0] BOX_X_HI = 18'sd4000;
  localparam logic signed [BoxW-1:0] BOX_Y_HI = 18'sd1872;
  localparam logic signed [BoxW-1:0] BOX_Z_HI = 18'sd16400;

  localparam logic signed [CodeW-1:0] PDG_ELECTRON = 32'sd11;
  localparam logic signed [CodeW-1:0] PDG_POSITRON = -32'sd11;
  localparam logic signed [CodeW-1:0] PDG_PHOTON   = 32'sd22;
  localparam logic signed [CodeW-1:0] PDG_PI0      = 32'sd111;
  localparam logic signed [CodeW-1:0] PDG_PROTON   = 32'sd2212;
  localparam logic signed [CodeW-1:0] PDG_MUON     = 32'sd13;
  localparam logic signed [CodeW-1:0] PDG_ANTIMUON = -32'sd13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHOWER_MIN = 3'd0,
    CFG_MUON_MIN   = 3'd1,
    CFG_PROTON_MIN = 3'd2,
    CFG_MARGIN     = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic muon;
    logic proton;
    logic shower;
    logic vertex;
    logic last;
  } epsf_cls_t;

endpackage

### hdl/epsf_front.sv
module epsf_front
  import epsf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgW-1:0]           cfg_wdata,
  input  logic                      is_beam_record,
  input  logic signed [CoordW-1:0]  vertex_x,
  input  logic signed [CoordW-1:0]  vertex_y,
  input  logic signed [CoordW-1:0]  vertex_z,
  input  logic                      is_simulated,
  input  logic signed [CodeW-1:0]   particle_code,
  input  logic [EnergyW-1:0]        energy_deposit,
  input  logic                      last_in_event,
  output epsf_cls_t                 cls
);

  logic [EnergyW-1:0] shower_min_r;
  logic [EnergyW-1:0] muon_min_r;
  logic [EnergyW-1:0] proton_min_r;
  logic [MarginW-1:0] margin_r;

  logic signed [BoxW-1:0] x_ext;
  logic signed [BoxW-1:0] y_ext;
  logic signed [BoxW-1:0] z_ext;
  logic signed [BoxW-1:0] m_ext;
  logic in_x;
  logic in_y;
  logic in_z;
  logic is_shower;
  logic is_proton;
  logic is_muon;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shower_min_r <= '0;
      muon_min_r   <= '0;
      proton_min_r <= '0;
      margin_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHOWER_MIN: shower_min_r <= cfg_wdata[EnergyW-1:0];
        CFG_MUON_MIN:   muon_min_r   <= cfg_wdata[EnergyW-1:0];
        CFG_PROTON_MIN: proton_min_r <= cfg_wdata[EnergyW-1:0];
        CFG_MARGIN:     margin_r     <= cfg_wdata[MarginW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    x_ext = {{(BoxW-CoordW){vertex_x[CoordW-1]}}, vertex_x};
    y_ext = {{(BoxW-CoordW){vertex_y[CoordW-1]}}, vertex_y};
    z_ext = {{(BoxW-CoordW){vertex_z[CoordW-1]}}, vertex_z};
    m_ext = {{(BoxW-MarginW){1'b0}}, margin_r};

    in_x = (x_ext > m_ext) && (x_ext < (BOX_X_HI - m_ext));
    in_y = (y_ext != '0) && (y_ext > (m_ext - BOX_Y_HI)) && (y_ext < (BOX_Y_HI - m_ext));
    in_z = (z_ext > m_ext) && (z_ext < (BOX_Z_HI - m_ext));

    is_shower = (particle_code == PDG_ELECTRON) || (particle_code == PDG_POSITRON) ||
                (particle_code == PDG_PHOTON)   || (particle_code == PDG_PI0);
    is_proton = (particle_code == PDG_PROTON);
    is_muon   = (particle_code == PDG_MUON) || (particle_code == PDG_ANTIMUON);

    cls.vertex = is_beam_record && in_x && in_y && in_z;
    cls.shower = is_simulated && is_shower && (energy_deposit >= shower_min_r);
    cls.proton = is_simulated && is_proton && (energy_deposit >= proton_min_r);
    cls.muon   = is_simulated && is_muon   && (energy_deposit >= muon_min_r);
    cls.last   = last_in_event;
  end

endmodule

### hdl/epsf_queue.sv
module epsf_queue
  import epsf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  epsf_cls_t push_data,
  output logic      full,
  input  logic      pop,
  output epsf_cls_t pop_data,
  output logic      empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  epsf_cls_t       mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == CntFull);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/epsf_back.sv
module epsf_back
  import epsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  epsf_cls_t item,
  output logic      item_pop,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_tdata
);

  epsf_cls_t  flags_r;
  epsf_cls_t  flags_nxt;
  epsf_cls_t  merged;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [4:0] out_data_r;
  logic [4:0] out_data_nxt;

  assign item_pop   = item_valid && (!item.last || !out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

  always_comb begin
    merged        = flags_r | item;
    merged.last   = 1'b0;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (item_pop) begin
      if (item.last) begin
        flags_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = {merged.vertex, merged.shower, merged.proton, merged.muon,
                         merged.muon && (merged.proton || merged.shower) && merged.vertex};
      end else begin
        flags_nxt = merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_last_loads_out : assert property (@(posedge clk) disable iff (!rst_n)
    item_pop && item.last |=> out_valid_r)
    else $error("last record popped without loading a result");

  a_last_clears_flags : assert property (@(posedge clk) disable iff (!rst_n)
    item_pop && item.last |=> flags_r == '0)
    else $error("event flags not cleared after last record");

  a_flags_accumulate : assert property (@(posedge clk) disable iff (!rst_n)
    item_pop && !item.last |=> flags_r == (($past(flags_r) | $past(item)) & ~5'b00001))
    else $error("event flags lost a record's hit");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(item_pop && item.last))
    else $error("pending result overwritten");

endmodule

### hdl/event_particle_selection_filter.sv
// Channel | Dir | tdata (low bit up)                           | tuser / tlast
// in_     | in  | vertex_x, vertex_y, vertex_z, particle_code, | tuser: is_beam_record,
//         |     | energy_deposit (104 bits)                    | is_simulated; tlast: last_in_event
// out_    | out | keep_event, saw_muon, saw_proton, saw_shower,| none
//         |     | vertex_inside, 3 zero bits                   |
// cfg_    | in  | write enable, 3-bit index, 24-bit data       | none
// One record per cycle while the queue is not full; the front classifies a record in its transfer
// cycle, and the result is registered in the back after the queue hands it the last record.
// Sustained rate is one record per clock unless a stalled output holds the back on a last record.
// Synchronous active-low reset clears flags, queue and thresholds (thresholds to zero).
// A stalled output holds the back only on a last record; the queue absorbs QUEUE_DEPTH records.
module event_particle_selection_filter
  import epsf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [103:0]       in_tdata,  // vertex_x, vertex_y, vertex_z, particle_code, energy_deposit
  input  logic [1:0]         in_tuser,  // is_beam_record, is_simulated
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata  // keep_event, saw_muon, saw_proton, saw_shower, vertex_inside
);

  epsf_cls_t cls;
  epsf_cls_t q_item;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  assign in_tready = !q_full;

  epsf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .is_beam_record (in_tuser[0]),
    .vertex_x       (in_tdata[15:0]),
    .vertex_y       (in_tdata[31:16]),
    .vertex_z       (in_tdata[47:32]),
    .is_simulated   (in_tuser[1]),
    .particle_code  (in_tdata[79:48]),
    .energy_deposit (in_tdata[103:80]),
    .last_in_event  (in_tlast),
    .cls            (cls)
  );

  epsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_item),
    .empty     (q_empty)
  );

  epsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### test/epsf_checker.sv
`timescale 1ns / 1ps
module selection_checker
  import epsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [103:0]       in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               in_tlast,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [7:0]         out_tdata,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int PrintCap = 60;

  typedef struct packed {
    logic keep;
    logic muon;
    logic proton;
    logic shower;
    logic vertex;
  } verdict_t;

  logic [EnergyW-1:0] shower_min;
  logic [EnergyW-1:0] muon_min;
  logic [EnergyW-1:0] proton_min;
  logic [MarginW-1:0] margin;
  logic               seen_muon;
  logic               seen_proton;
  logic               seen_shower;
  logic               seen_vertex;
  verdict_t           verdict_q[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintCap) begin
      $display("[%0t] checker: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %b want %b", name, got, want));
    end
  endtask

  task automatic absorb_record(input logic [103:0] data, input logic [1:0] user,
                               input logic last);
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic signed [CodeW-1:0]  code;
    logic [EnergyW-1:0]       energy;
    int                       m;
    verdict_t                 v;
    x      = data[15:0];
    y      = data[31:16];
    z      = data[47:32];
    code   = data[79:48];
    energy = data[103:80];
    m      = int'(margin);
    if (user[0] &&
        int'(x) > m && int'(x) < int'(BOX_X_HI) - m &&
        y != 0 && int'(y) > m - int'(BOX_Y_HI) && int'(y) < int'(BOX_Y_HI) - m &&
        int'(z) > m && int'(z) < int'(BOX_Z_HI) - m) begin
      seen_vertex = 1'b1;
    end
    if (user[1]) begin
      if (code == PDG_ELECTRON || code == PDG_POSITRON ||
          code == PDG_PHOTON || code == PDG_PI0) begin
        if (energy >= shower_min) seen_shower = 1'b1;
      end else if (code == PDG_PROTON) begin
        if (energy >= proton_min) seen_proton = 1'b1;
      end else if (code == PDG_MUON || code == PDG_ANTIMUON) begin
        if (energy >= muon_min) seen_muon = 1'b1;
      end
    end
    if (last) begin
      v.keep   = seen_muon && (seen_proton || seen_shower) && seen_vertex;
      v.muon   = seen_muon;
      v.proton = seen_proton;
      v.shower = seen_shower;
      v.vertex = seen_vertex;
      verdict_q.push_back(v);
      seen_muon   = 1'b0;
      seen_proton = 1'b0;
      seen_shower = 1'b0;
      seen_vertex = 1'b0;
    end
  endtask

  task automatic check_result(input logic [7:0] d);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("result %b with no event pending", d));
    end else begin
      want = verdict_q.pop_front();
      compare_field("keep_event", d[0], want.keep);
      compare_field("saw_muon", d[1], want.muon);
      compare_field("saw_proton", d[2], want.proton);
      compare_field("saw_shower", d[3], want.shower);
      compare_field("vertex_inside", d[4], want.vertex);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shower_min  = '0;
      muon_min    = '0;
      proton_min  = '0;
      margin      = '0;
      seen_muon   = 1'b0;
      seen_proton = 1'b0;
      seen_shower = 1'b0;
      seen_vertex = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHOWER_MIN: shower_min = cfg_wdata[EnergyW-1:0];
          CFG_MUON_MIN:   muon_min   = cfg_wdata[EnergyW-1:0];
          CFG_PROTON_MIN: proton_min = cfg_wdata[EnergyW-1:0];
          CFG_MARGIN:     margin     = cfg_wdata[MarginW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) absorb_record(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) check_result(out_tdata);
    end
    outstanding <= verdict_q.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import epsf_pkg::*;

  localparam int DrainCycles = 12;
  localparam int RegCount    = 4;
  localparam int CfgTop      = 2 ** CfgIdxW - 1;
  localparam logic [EnergyW-1:0] EnergyMax = '1;

  typedef enum int {READY_ALWAYS, READY_NEVER, READY_SPOTTY} ready_mode_t;

  typedef struct packed {
    logic               beam;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [CoordW-1:0]  z;
    logic               sim;
    logic [CodeW-1:0]   code;
    logic [EnergyW-1:0] energy;
    logic               last;
  } record_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [CfgW-1:0]    cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [103:0]       in_tdata   = '0;
  logic [1:0]         in_tuser   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  int                 mismatches;
  int                 outstanding;

  int                 burst_left = 0;
  int                 stall_left = 0;
  ready_mode_t        stall_mode = READY_ALWAYS;
  logic [EnergyW-1:0] thr_shower = '0;
  logic [EnergyW-1:0] thr_muon   = '0;
  logic [EnergyW-1:0] thr_proton = '0;
  int                 box_margin = 0;

  event_particle_selection_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  selection_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = ready_mode_t'($urandom_range(READY_ALWAYS, READY_SPOTTY));
      stall_left = $urandom_range(1, 16);
    end
    stall_left--;
    case (stall_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_NEVER:  out_tready <= 1'b0;
      default:      out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic record_t make_rec(input bit beam, input int x, input int y, input int z,
                                       input bit sim, input int code, input int energy,
                                       input bit last);
    record_t r;
    r.beam   = beam;
    r.x      = x[CoordW-1:0];
    r.y      = y[CoordW-1:0];
    r.z      = z[CoordW-1:0];
    r.sim    = sim;
    r.code   = code;
    r.energy = energy[EnergyW-1:0];
    r.last   = last;
    return r;
  endfunction

  // hold each transfer until accepted; gaps only open between bursts
  task automatic send_record(input record_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.energy, r.code, r.z, r.y, r.x};
    in_tuser  <= {r.sim, r.beam};
    in_tlast  <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic load_config(input logic [EnergyW-1:0] shower, input logic [EnergyW-1:0] muon,
                             input logic [EnergyW-1:0] proton, input logic [MarginW-1:0] fm);
    logic [CfgIdxW-1:0] stray;
    logic [CfgW-1:0]    w;
    stray = CfgIdxW'($urandom_range(RegCount, CfgTop));
    w     = CfgW'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= stray;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_SHOWER_MIN;
    cfg_wdata <= shower;
    @(posedge clk);
    cfg_index <= CFG_MUON_MIN;
    cfg_wdata <= muon;
    @(posedge clk);
    cfg_index <= CFG_PROTON_MIN;
    cfg_wdata <= proton;
    @(posedge clk);
    w              = CfgW'($urandom);
    w[MarginW-1:0] = fm;
    cfg_index <= CFG_MARGIN;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_shower = shower;
    thr_muon   = muon;
    thr_proton = proton;
    box_margin = int'(fm);
  endtask

  function automatic logic [CoordW-1:0] pick_coord(input int lo, input int hi);
    int span;
    int v;
    span = (hi > lo) ? hi - lo : 0;
    case ($urandom_range(0, 5))
      0:       v = lo + int'($urandom_range(0, 4)) - 2;
      1:       v = hi + int'($urandom_range(0, 4)) - 2;
      2:       v = lo + int'($urandom_range(0, span));
      3:       v = 0;
      default: v = $urandom;
    endcase
    return v[CoordW-1:0];
  endfunction

  function automatic logic [EnergyW-1:0] pick_energy();
    logic [EnergyW-1:0] t;
    case ($urandom_range(0, 2))
      0:       t = thr_shower;
      1:       t = thr_muon;
      default: t = thr_proton;
    endcase
    case ($urandom_range(0, 6))
      0, 1:    return t;
      2:       return t - 1'b1;
      3:       return t + 1'b1;
      4:       return '0;
      5:       return EnergyMax;
      default: return EnergyW'($urandom);
    endcase
  endfunction

  function automatic logic [CodeW-1:0] pick_code();
    case ($urandom_range(0, 11))
      0:       return PDG_ELECTRON;
      1:       return PDG_POSITRON;
      2:       return PDG_PHOTON;
      3:       return PDG_PI0;
      4:       return PDG_PROTON;
      5, 6:    return PDG_MUON;
      7:       return PDG_ANTIMUON;
      8:       return PDG_MUON + 1;
      9:       return PDG_PROTON - 1;
      10:      return -PDG_PHOTON;
      default: return $urandom;
    endcase
  endfunction

  function automatic record_t random_record(input bit tidy, input bit head, input bit last);
    record_t r;
    int      kind;
    kind = $urandom_range(0, 9);
    if (tidy) kind = head ? 0 : ((kind == 0 || kind == 9) ? 1 : kind);
    r.beam = (kind == 0) || (kind == 9 && $urandom_range(0, 1) == 1);
    if (kind == 9) begin
      r.x      = CoordW'($urandom);
      r.y      = CoordW'($urandom);
      r.z      = CoordW'($urandom);
      r.sim    = 1'($urandom_range(0, 1));
      r.code   = $urandom;
      r.energy = EnergyW'($urandom);
    end else begin
      r.x      = pick_coord(box_margin, int'(BOX_X_HI) - box_margin);
      r.y      = pick_coord(box_margin - int'(BOX_Y_HI), int'(BOX_Y_HI) - box_margin);
      r.z      = pick_coord(box_margin, int'(BOX_Z_HI) - box_margin);
      r.sim    = (kind == 0) ? ($urandom_range(0, 3) == 0) : (kind != 8);
      r.code   = pick_code();
      r.energy = pick_energy();
    end
    r.last = last;
    return r;
  endfunction

  task automatic random_events(input int n_records);
    int sent;
    int len;
    bit tidy;
    sent = 0;
    while (sent < n_records) begin
      len  = $urandom_range(1, 6);
      tidy = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < len; i++) begin
        send_record(random_record(tidy, i == 0, i == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: any deposit passes, box at full size
    send_record(make_rec(1, 2000, 100, 8000, 1, PDG_MUON, 0, 1));
    send_record(make_rec(1, 1, -1, 1, 1, PDG_PROTON, 24'hFFFFFF, 0));
    send_record(make_rec(0, -32768, -32768, -32768, 1, PDG_ANTIMUON, 0, 0));
    send_record(make_rec(0, 32767, 32767, 32767, 0, PDG_ELECTRON, 0, 1));
    send_record(make_rec(1, 0, 100, 8000, 1, PDG_POSITRON, 5, 0));
    send_record(make_rec(1, 2000, 0, 8000, 1, PDG_PHOTON, 0, 0));
    send_record(make_rec(1, 4000, 100, 8000, 0, PDG_MUON, 0, 0));
    send_record(make_rec(1, 2000, 1872, 8000, 0, PDG_PROTON, 0, 0));
    send_record(make_rec(1, 2000, -1872, 8000, 0, 0, 0, 0));
    send_record(make_rec(1, 2000, 100, 0, 0, 0, 0, 0));
    send_record(make_rec(1, 2000, 100, 16400, 0, 0, 0, 0));
    send_record(make_rec(0, 2000, 100, 8000, 1, PDG_MUON + 1, 0, 1));
    send_record(make_rec(1, 3999, -1871, 16399, 1, PDG_PI0, 0, 1));
    send_record(make_rec(1, 3999, 1871, 1, 1, PDG_PROTON - 1, 0, 1));
    settle();

    load_config(24'h001000, 24'h000800, 24'h002000, 13'd400);
    send_record(make_rec(0, 2000, 100, 8000, 1, PDG_MUON, 24'h0007FF, 0));
    send_record(make_rec(0, 2000, 100, 8000, 1, PDG_PROTON, 24'h001FFF, 0));
    send_record(make_rec(0, 2000, 100, 8000, 1, PDG_PHOTON, 24'h000FFF, 0));
    send_record(make_rec(1, 400, 100, 8000, 0, 0, 0, 0));
    send_record(make_rec(1, 3600, 100, 8000, 0, 0, 0, 0));
    send_record(make_rec(1, 2000, -1472, 8000, 0, 0, 0, 0));
    send_record(make_rec(1, 2000, 1472, 8000, 0, 0, 0, 0));
    send_record(make_rec(1, 2000, 100, 400, 0, 0, 0, 0));
    send_record(make_rec(1, 2000, 100, 16000, 0, 0, 0, 1));
    send_record(make_rec(1, 401, -1471, 401, 1, PDG_MUON, 24'h000800, 0));
    send_record(make_rec(0, 2000, 100, 8000, 1, PDG_ELECTRON, 24'h001000, 1));
    send_record(make_rec(1, 3599, 1471, 15999, 1, PDG_PROTON, 24'h002000, 1));
    settle();

    load_config(EnergyMax, EnergyMax, EnergyMax, 13'h1FFF);
    random_events(300);
    settle();
    load_config('0, '0, '0, '0);
    random_events(350);
    for (int p = 0; p < 4; p++) begin
      settle();
      load_config(EnergyW'($urandom), EnergyW'($urandom), EnergyW'($urandom),
                  (p == 3) ? MarginW'($urandom) : MarginW'($urandom_range(0, 2100)));
      random_events(300);
    end
    settle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
